[rtl/wheel_speed_pi_controller_core_assert.svh]
// Assertion macros for the speed loop RTL.
`ifndef WHEEL_SPEED_PI_CONTROLLER_CORE_ASSERT_SVH
`define WHEEL_SPEED_PI_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WSPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wspc assertion failed");

// Next-cycle implication, disabled during reset.
`define WSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wspc assertion failed");

`endif

[rtl/wspc_pkg.sv]
`default_nettype none

package wspc_pkg;

  // Multiplier operand / result widths
  localparam int A_W    = 32;
  localparam int B_W    = 25;
  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int GAIN_W = 24;
  localparam int ERR_W  = 18;
  localparam int SUM_W  = 34;

  // Low-pass coefficients, Q0.16
  localparam logic signed [B_W-1:0] COEF_OLD = 25'sd55706;
  localparam logic signed [B_W-1:0] COEF_NEW = 25'sd9830;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 58'sd32768;
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = 58'sd67108863;  // 2^26 - 1
  localparam int FILT_LSB  = 16;
  localparam int DRIVE_LSB = 26;
  localparam int ERR_SHIFT = 14;

  localparam logic signed [SUM_W-1:0] INTEG_LIMIT = 34'sd163840000;  // 10000 in Q18.14
  localparam logic signed [15:0]      TILT_LIMIT  = 16'sd7680;       // 30 deg in Q8.8

  // Accumulator operations
  localparam logic [2:0] ACC_HOLD      = 3'd0;
  localparam logic [2:0] ACC_LOAD_BIAS = 3'd1;
  localparam logic [2:0] ACC_ADD_SHL   = 3'd2;
  localparam logic [2:0] ACC_LOAD_NEG  = 3'd3;
  localparam logic [2:0] ACC_SUB       = 3'd4;

  // Register indexes
  localparam logic REG_GAIN_P = 1'b0;
  localparam logic REG_GAIN_I = 1'b1;

  typedef struct packed {
    logic       prod_en;
    logic [2:0] acc_op;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/wspc_cfg.sv]
`default_nettype none

module wspc_cfg
  import wspc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [GAIN_W-1:0] gain_p,
  output logic [GAIN_W-1:0] gain_i
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Word select on paddr[2]; byte offset bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
    end else if (wr) begin
      if (paddr[2] == REG_GAIN_P) begin
        gain_p <= pwdata[GAIN_W-1:0];
      end else begin
        gain_i <= pwdata[GAIN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_GAIN_P) begin
      prdata = {8'd0, gain_p};
    end else begin
      prdata = {8'd0, gain_i};
    end
  end

endmodule

`default_nettype wire

[rtl/wspc_mac.sv]
`default_nettype none

module wspc_mac
  import wspc_pkg::*;
(
  input  logic                    clk,
  input  mac_ctrl_t               ctrl,
  input  logic signed [A_W-1:0]   op_a,
  input  logic signed [B_W-1:0]   op_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;

  assign prod_x = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= op_a * op_b;
    end
    unique case (ctrl.acc_op)
      ACC_HOLD:      acc <= acc;
      ACC_LOAD_BIAS: acc <= prod_x + ROUND_BIAS;
      ACC_ADD_SHL:   acc <= acc + (prod_x <<< ERR_SHIFT);
      ACC_LOAD_NEG:  acc <= -prod_x;
      ACC_SUB:       acc <= acc - prod_x;
      default:       acc <= acc;
    endcase
  end

endmodule

`default_nettype wire

[rtl/wheel_speed_pi_controller_core.sv]
// Each item runs through steps M1 to D and lands in the output register in D;
// no new item is taken until it leaves D. A single 32x25 multiplier and its
//   accumulator are stepped through four products by the sequencer.
// in_stall is high while an item is in flight; a held result waits in the
//   output register and the next item may be taken meanwhile.
// Synchronous active-high reset clears gains, filter and integral state.
`default_nettype none
`include "wheel_speed_pi_controller_core_assert.svh"

module wheel_speed_pi_controller_core
  import wspc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  input  logic signed [15:0] tilt_angle,
  input  logic               low_voltage,
  input  logic               stop_request,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] drive,
  output logic               motor_off,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Sequencer steps:
  //   M1  prod = filtered * 0.85
  //   M2  prod = err * 0.15, acc = prev prod + rounding bias
  //   A1  acc += prod << 14
  //   F   filtered = acc >> 16, integral = clamp(integral + filtered)
  //   M3  prod = filtered * Kp
  //   M4  prod = integral * Ki, acc = -prev prod
  //   A2  acc -= prod
  //   D   truncate/saturate drive, present result, clear integral on shutdown or stop
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_M2   = 4'd2;
  localparam logic [3:0] ST_A1   = 4'd3;
  localparam logic [3:0] ST_F    = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_M4   = 4'd6;
  localparam logic [3:0] ST_A2   = 4'd7;
  localparam logic [3:0] ST_D    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;

  // Loop state, Q18.14
  logic signed [A_W-1:0] filtered;
  logic signed [A_W-1:0] integral;

  // Per-item latched values
  logic signed [ERR_W-1:0] err;
  logic                    off_flag;
  logic                    clr_flag;

  mac_ctrl_t               mac_ctrl;
  logic signed [A_W-1:0]   op_a;
  logic signed [B_W-1:0]   op_b;
  logic signed [ACC_W-1:0] acc;

  logic in_xfer;
  logic out_free;
  logic tilt_off;

  logic signed [A_W-1:0]   filt_new;
  logic signed [SUM_W-1:0] integ_sum;
  logic signed [A_W-1:0]   integ_clamped;

  logic signed [ACC_W-1:0]           acc_rnd;
  logic signed [ACC_W-DRIVE_LSB-1:0] drive_q;
  logic signed [15:0]                drive_sat;

  wspc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain_p  (gain_p),
    .gain_i  (gain_i)
  );

  wspc_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Shutdown: tilt at or beyond +/-30 deg, or battery fault
  assign tilt_off = (tilt_angle <= -TILT_LIMIT) || (tilt_angle >= TILT_LIMIT);

  // Filter result: floor shift of the rounded mix, kept to 32 bits
  assign filt_new  = acc[FILT_LSB+A_W-1:FILT_LSB];
  assign integ_sum = SUM_W'(integral) + SUM_W'(filt_new);

  always_comb begin
    if (integ_sum > INTEG_LIMIT) begin
      integ_clamped = A_W'(INTEG_LIMIT);
    end else if (integ_sum < -INTEG_LIMIT) begin
      integ_clamped = A_W'(-INTEG_LIMIT);
    end else begin
      integ_clamped = integ_sum[A_W-1:0];
    end
  end

  // Truncate toward zero by 2^26, then saturate to 16 bits
  assign acc_rnd = acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0);
  assign drive_q = acc_rnd[ACC_W-1:DRIVE_LSB];

  always_comb begin
    if (drive_q > (ACC_W-DRIVE_LSB)'(32767)) begin
      drive_sat = 16'sd32767;
    end else if (drive_q < -(ACC_W-DRIVE_LSB)'(32768)) begin
      drive_sat = -16'sd32768;
    end else begin
      drive_sat = drive_q[15:0];
    end
  end

  // Operand steering and MAC control per step
  always_comb begin
    op_a           = filtered;
    op_b           = COEF_OLD;
    mac_ctrl       = '{prod_en: 1'b0, acc_op: ACC_HOLD};
    unique case (state)
      ST_M1: begin
        mac_ctrl.prod_en = 1'b1;
      end
      ST_M2: begin
        op_a     = A_W'(err);
        op_b     = COEF_NEW;
        mac_ctrl = '{prod_en: 1'b1, acc_op: ACC_LOAD_BIAS};
      end
      ST_A1: begin
        mac_ctrl.acc_op = ACC_ADD_SHL;
      end
      ST_M3: begin
        op_b             = B_W'({1'b0, gain_p});
        mac_ctrl.prod_en = 1'b1;
      end
      ST_M4: begin
        op_a     = integral;
        op_b     = B_W'({1'b0, gain_i});
        mac_ctrl = '{prod_en: 1'b1, acc_op: ACC_LOAD_NEG};
      end
      ST_A2: begin
        mac_ctrl.acc_op = ACC_SUB;
      end
      ST_IDLE, ST_F, ST_D: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_A1;
      ST_A1:   state_next = ST_F;
      ST_F:    state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_A2;
      ST_A2:   state_next = ST_D;
      ST_D:    if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      filtered  <= '0;
      integral  <= '0;
    end else begin
      state <= state_next;

      if (state == ST_F) begin
        filtered <= filt_new;
        integral <= integ_clamped;
      end

      // Drive uses the integral before the shutdown clear
      if (state == ST_D && out_free) begin
        out_valid <= 1'b1;
        if (clr_flag) begin
          integral <= '0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item latch and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err      <= -(ERR_W'(left_count) + ERR_W'(right_count));
      off_flag <= tilt_off || low_voltage;
      clr_flag <= tilt_off || low_voltage || stop_request;
    end
    if (state == ST_D && out_free) begin
      drive     <= drive_sat;
      motor_off <= off_flag;
    end
  end

  `WSPC_ASSERT_NEXT(a_start_m1, clk, rst, in_xfer, state == ST_M1)
  `WSPC_ASSERT_NOW(a_integ_bound, clk, rst, 1'b1,
                   (SUM_W'(integral) <= INTEG_LIMIT) && (SUM_W'(integral) >= -INTEG_LIMIT))
  `WSPC_ASSERT_NEXT(a_clear_on_off, clk, rst, (state == ST_D) && out_free && clr_flag,
                    integral == '0)
  `WSPC_ASSERT_NEXT(a_result_shown, clk, rst, (state == ST_D) && out_free,
                    out_valid && (state == ST_IDLE))

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import wspc_pkg::*;

  // Predictor constants: low-pass weights in Q0.16, integral clamp in Q18.14,
  // tilt trip point in Q8.8 degrees (30 deg).
  localparam longint LPF_OLD     = 55706;
  localparam longint LPF_NEW     = 9830;
  localparam longint INTEG_MAX   = 64'sd10000 * 64'sd16384;
  localparam int     TILT_TRIP   = 7680;
  localparam int     DRIVE_MAX   = 32767;
  localparam int     DRIVE_MIN   = -32768;
  localparam int     PHASE_TICKS = 300;

  typedef struct {
    logic signed [15:0] lcount;
    logic signed [15:0] rcount;
    logic signed [15:0] tilt;
    logic               lowv;
    logic               stop;
  } tick_t;

  typedef struct {
    logic signed [15:0] drive;
    logic               motor_off;
  } motor_cmd_t;

  // DUT signals; every input starts at a known value.
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic signed [15:0] left_count   = '0;
  logic signed [15:0] right_count  = '0;
  logic signed [15:0] tilt_angle   = '0;
  logic               low_voltage  = 1'b0;
  logic               stop_request = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic signed [15:0] drive;
  logic               motor_off;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [2:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state: gains as last written, filter and integral.
  logic [23:0]        gain_p_model;
  logic [23:0]        gain_i_model;
  logic signed [31:0] lpf_state;
  logic signed [31:0] integ_state;

  // Commands predicted for accepted ticks, oldest first.
  motor_cmd_t pending_cmds[$];

  // Knobs for the random idling on each side.
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  int stall_run = 0;

  // Run statistics.
  int fail_count     = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int gain_settings  = 0;
  int shutdown_count = 0;
  int clamp_count    = 0;
  int sat_count      = 0;

  always #2 clk = ~clk;

  wheel_speed_pi_controller_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_count   (left_count),
    .right_count  (right_count),
    .tilt_angle   (tilt_angle),
    .low_voltage  (low_voltage),
    .stop_request (stop_request),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive        (drive),
    .motor_off    (motor_off),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Gap length: mostly none or short, a few long ones.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // One control tick of the speed loop: low-pass the error, integrate with
  // clamp, form -Kp*filt - Ki*integ in Q.26, truncate toward zero, saturate.
  // The integral clear on shutdown or stop happens after the drive is formed.
  function automatic motor_cmd_t predict_speed_loop(tick_t t);
    longint err_q14, mix, filt, integ, acc, drv;
    motor_cmd_t cmd;
    err_q14 = -(longint'(t.lcount) + longint'(t.rcount)) * 64'sd16384;
    mix     = longint'(lpf_state) * LPF_OLD + err_q14 * LPF_NEW;
    filt    = (mix + 64'sd32768) >>> 16;
    lpf_state = filt[31:0];

    integ = longint'(integ_state) + filt;
    if (integ > INTEG_MAX) begin
      integ = INTEG_MAX;
      clamp_count++;
    end else if (integ < -INTEG_MAX) begin
      integ = -INTEG_MAX;
      clamp_count++;
    end
    integ_state = integ[31:0];

    acc = -(filt * longint'(gain_p_model)) - (integ * longint'(gain_i_model));
    drv = (acc < 0) ? -((-acc) >>> 26) : (acc >>> 26);
    if (drv > DRIVE_MAX) begin
      drv = DRIVE_MAX;
      sat_count++;
    end else if (drv < DRIVE_MIN) begin
      drv = DRIVE_MIN;
      sat_count++;
    end

    cmd.drive     = drv[15:0];
    cmd.motor_off = (t.tilt <= -TILT_TRIP) || (t.tilt >= TILT_TRIP) || t.lowv;
    if (cmd.motor_off || t.stop) begin
      integ_state = '0;
      shutdown_count++;
    end
    return cmd;
  endfunction

  function automatic tick_t mk_tick(int lc, int rc, int tl, bit lv, bit st);
    tick_t t;
    t.lcount = 16'(lc);
    t.rcount = 16'(rc);
    t.tilt   = 16'(tl);
    t.lowv   = lv;
    t.stop   = st;
    return t;
  endfunction

  // Random tick. Most are plausible robot ticks around a per-phase drift
  // (so the integral walks into its clamp); some are fully random, some sit
  // on the tilt trip points.
  function automatic tick_t random_tick(int bias);
    tick_t t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      t = mk_tick(bias + int'($urandom_range(0, 400)) - 200,
                  bias + int'($urandom_range(0, 400)) - 200,
                  int'($urandom_range(0, 15000)) - 7500,
                  $urandom_range(0, 99) < 3, $urandom_range(0, 99) < 3);
    end else if (r < 88) begin
      t.lcount = 16'($urandom);
      t.rcount = 16'($urandom);
      t.tilt   = 16'($urandom);
      t.lowv   = 1'($urandom);
      t.stop   = 1'($urandom);
    end else begin
      t = mk_tick(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                  0, 1'($urandom), $urandom_range(0, 9) == 0);
      case ($urandom_range(0, 5))
        0: t.tilt = 16'(TILT_TRIP);
        1: t.tilt = 16'(TILT_TRIP - 1);
        2: t.tilt = 16'(-TILT_TRIP);
        3: t.tilt = 16'(-TILT_TRIP + 1);
        4: t.tilt = 16'sh7fff;
        default: t.tilt = 16'sh8000;
      endcase
    end
    return t;
  endfunction

  // Register port: setup cycle then access cycle; the write lands at the
  // access edge (pready is tied high but still honored). The bus goes idle
  // again before the next transfer.
  task automatic apb_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_GAIN_P) gain_p_model = data[23:0];
    else gain_i_model = data[23:0];
  endtask

  task automatic apb_read(input logic idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Gains go in with junk in the unused top byte; only 24 bits must stick.
  task automatic apply_gains(input logic [23:0] kp, input logic [23:0] ki);
    apb_write(REG_GAIN_P, {8'($urandom), kp});
    apb_write(REG_GAIN_I, {8'($urandom), ki});
    gain_settings++;
  endtask

  function automatic logic [23:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 24'hffffff;
    if (r < 60) return 24'($urandom_range(0, 8192));
    if (r < 85) return 24'($urandom_range(0, 65535));
    return 24'($urandom);
  endfunction

  // One input transfer: hold valid and payload until the DUT takes it, then
  // record the predicted command and maybe leave a gap.
  task automatic send_tick(input tick_t t);
    int gap;
    left_count   <= t.lcount;
    right_count  <= t.rcount;
    tilt_angle   <= t.tilt;
    low_voltage  <= t.lowv;
    stop_request <= t.stop;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_cmds.push_back(predict_speed_loop(t));
    sent_count++;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Idle the input and wait for every predicted command to come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Output side: random stall bursts, mostly short, a few long.
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 8);
    end else if ($urandom_range(0, 99) < 40) begin
      out_stall <= 1'b1;
      stall_run <= pick_gap(1'b1);
    end
  end

  // Output check: every output transfer must match the oldest prediction.
  always @(posedge clk) begin
    motor_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected output transfer: drive %0d motor_off %0b", drive, motor_off);
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        checked_count++;
        if (drive !== want.drive) begin
          $error("drive mismatch: expected %0d, got %0d", want.drive, drive);
          fail_count++;
        end
        if (motor_off !== want.motor_off) begin
          $error("motor_off mismatch: expected %0b, got %0b", want.motor_off, motor_off);
          fail_count++;
        end
      end
    end
  end

  // Reset values, masking of the unused top byte, and read-back.
  task automatic test_register_access();
    logic [31:0] rd;
    apb_read(REG_GAIN_P, rd);
    if (rd !== 32'h0) begin
      $error("speed_gain_p reset mismatch: expected %0h, got %0h", 32'h0, rd);
      fail_count++;
    end
    apb_read(REG_GAIN_I, rd);
    if (rd !== 32'h0) begin
      $error("speed_gain_i reset mismatch: expected %0h, got %0h", 32'h0, rd);
      fail_count++;
    end
    apb_write(REG_GAIN_P, 32'ha5123456);
    apb_write(REG_GAIN_I, 32'hffffffff);
    apb_read(REG_GAIN_P, rd);
    if (rd !== 32'h00123456) begin
      $error("speed_gain_p readback mismatch: expected %0h, got %0h", 32'h00123456, rd);
      fail_count++;
    end
    apb_read(REG_GAIN_I, rd);
    if (rd !== 32'h00ffffff) begin
      $error("speed_gain_i readback mismatch: expected %0h, got %0h", 32'h00ffffff, rd);
      fail_count++;
    end
  endtask

  // Count extremes, integral clamp in both directions, tilt trip points on
  // either side of 30 deg, low voltage, stop request, and shutdown ticks
  // where the drive still uses the integral before it is cleared.
  task automatic test_directed();
    apply_gains(24'd4096, 24'd2048);
    send_tick(mk_tick(0, 0, 0, 1'b0, 1'b0));
    repeat (3) send_tick(mk_tick(-32768, -32768, 0, 1'b0, 1'b0));
    send_tick(mk_tick(-32768, -32768, TILT_TRIP, 1'b0, 1'b0));
    repeat (3) send_tick(mk_tick(32767, 32767, 0, 1'b0, 1'b0));
    send_tick(mk_tick(32767, -32768, -TILT_TRIP + 1, 1'b0, 1'b0));
    send_tick(mk_tick(-32768, 32767, TILT_TRIP - 1, 1'b0, 1'b0));
    send_tick(mk_tick(100, 50, TILT_TRIP, 1'b0, 1'b0));
    send_tick(mk_tick(100, 50, -TILT_TRIP, 1'b0, 1'b0));
    send_tick(mk_tick(-80, -90, 32767, 1'b0, 1'b0));
    send_tick(mk_tick(-80, -90, -32768, 1'b0, 1'b0));
    send_tick(mk_tick(200, 180, 0, 1'b1, 1'b0));
    send_tick(mk_tick(200, 180, 0, 1'b0, 1'b1));
    send_tick(mk_tick(-300, -250, TILT_TRIP, 1'b1, 1'b1));
    send_tick(mk_tick(5, -7, 256, 1'b0, 1'b0));
    drain();
  endtask

  // Gain corners: both full scale, both zero, and each alone at full scale.
  task automatic test_gain_extremes();
    apply_gains(24'hffffff, 24'hffffff);
    send_tick(mk_tick(-1, 0, 0, 1'b0, 1'b0));
    send_tick(mk_tick(1, 1, 0, 1'b0, 1'b0));
    send_tick(mk_tick(-32768, -32768, 0, 1'b0, 1'b0));
    drain();
    apply_gains(24'h0, 24'h0);
    send_tick(mk_tick(32767, 32767, 0, 1'b0, 1'b0));
    send_tick(mk_tick(-500, 400, 0, 1'b0, 1'b0));
    drain();
    apply_gains(24'hffffff, 24'h0);
    send_tick(mk_tick(3, 4, 0, 1'b0, 1'b0));
    drain();
    apply_gains(24'h0, 24'hffffff);
    send_tick(mk_tick(-3, -4, 0, 1'b0, 1'b0));
    drain();
  endtask

  // Random phases, each with its own gains and drift; one runs with no
  // idling on either side so back-to-back transfers get exercised.
  task automatic test_random_phases();
    int bias;
    for (int p = 0; p < 6; p++) begin
      apply_gains(pick_gain(), pick_gain());
      bias     = int'($urandom_range(0, 600)) - 300;
      gaps_on  = (p != 2);
      stall_on = (p != 2);
      for (int n = 0; n < PHASE_TICKS; n++) send_tick(random_tick(bias));
      drain();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Sender holds off until the output side has caught up completely, then
  // resumes from an idle block with state carried over.
  task automatic test_drain_pause();
    apply_gains(24'd8192, 24'd1024);
    for (int n = 0; n < 25; n++) send_tick(random_tick(150));
    drain();
    for (int n = 0; n < 25; n++) send_tick(random_tick(-150));
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gain_p_model = '0;
    gain_i_model = '0;
    lpf_state    = '0;
    integ_state  = '0;

    test_register_access();
    test_directed();
    test_gain_extremes();
    test_random_phases();
    test_drain_pause();

    drain();
    // Leave room for any stray output transfer.
    repeat (40) @(posedge clk);

    $display("Sent %0d ticks over %0d gain settings; %0d commands checked.",
             sent_count, gain_settings, checked_count);
    $display("Shutdown/stop ticks %0d, integral clamps %0d, drive saturations %0d.",
             shutdown_count, clamp_count, sat_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a time limit several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("Timeout: %0d ticks sent, %0d commands outstanding",
             sent_count, pending_cmds.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/wspc_pkg.sv
rtl/wspc_cfg.sv
rtl/wspc_mac.sv
rtl/wheel_speed_pi_controller_core.sv
test/testbench.sv
